// ===== design/pst_pkg.sv =====
// Shared constants for the prefix-sum tree table.
`default_nettype none

package pst_pkg;

  // Number of tree nodes; node 0 is never used.
  localparam int unsigned TreeSize = 1024;
  // Width of a node index.
  localparam int unsigned PosW = $clog2(TreeSize);
  // Width of one counter.
  localparam int unsigned NodeW = 64;

  // Request codes.
  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

`default_nettype wire

// ===== design/prefix_sum_tree_table.sv =====
// Prefix-sum tree table: a binary indexed tree of 64-bit counters with a walk sequencer.
//
// Usage: a request word (op_i, position_i, delta_i) is taken at a rising edge where
// start is high and busy is low. An add request (op_i = 0) adds delta_i, wrapping,
// at the one-based position and returns nothing. A query request (op_i = 1) returns
// the wrapping sum of entries 1 through position_i on prefix_total_o, marked by
// result_valid_o for exactly one cycle. Position 0 is an ignored add or a zero sum.
// Timing: one node is read per cycle from the node memory, the single read port
// sets the pace. A request visits at most log2(1024) = 10 nodes; busy stays high
// from acceptance through its walk and final step, and the next word is taken only
// once busy is low again, so one request finishes before the next one starts.
// A query's result word appears in the same cycle that busy drops.
// Adds overlap the write of one node with the read of the next, in one adder.
// Reset: after rst_ni rises, a clearing pass writes zero to all 1024 nodes, one
// per cycle; busy stays high for the whole pass and no request is taken.
// The receiver cannot stall: each result word is shown for one cycle only.
`default_nettype none

module prefix_sum_tree_table (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       op_i,
  input  wire logic [pst_pkg::PosW-1:0]   position_i,
  input  wire logic [pst_pkg::NodeW-1:0]  delta_i,
  output logic                            result_valid_o,
  output logic [pst_pkg::NodeW-1:0]       prefix_total_o
);

  localparam int unsigned CurW = pst_pkg::PosW + 1;

  // Sequencer state codes.
  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StWalk  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [pst_pkg::PosW-1:0]  clr_idx_q, clr_idx_d;
  logic [CurW-1:0]           cur_q, cur_d;
  logic                      op_q, op_d;
  logic [pst_pkg::NodeW-1:0] delta_q, delta_d;
  logic [pst_pkg::NodeW-1:0] total_q, total_d;
  logic                      pend_q, pend_d;
  logic [pst_pkg::PosW-1:0]  pend_addr_q, pend_addr_d;
  logic                      res_valid_q, res_valid_d;
  logic [pst_pkg::NodeW-1:0] res_total_q, res_total_d;

  logic [pst_pkg::NodeW-1:0] mem [pst_pkg::TreeSize];
  logic [pst_pkg::NodeW-1:0] rd_q;

  logic                      rd_en;
  logic                      wr_en;
  logic [pst_pkg::PosW-1:0]  wr_addr;
  logic [pst_pkg::NodeW-1:0] wr_data;
  logic [pst_pkg::NodeW-1:0] sum;
  logic [CurW-1:0]           cur_lsb;
  logic                      walk_done;

  // Shared adder: node plus delta for adds, running total plus node for queries.
  assign sum = rd_q + ((op_q == pst_pkg::OpQuery) ? total_q : delta_q);

  // Lowest set bit of the walk index and the end of the walk.
  assign cur_lsb   = cur_q & (~cur_q + CurW'(1));
  assign walk_done = (cur_q == '0) || cur_q[CurW-1];

  // Memory write port: clearing pass or the pending node update of an add.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr_q;
    wr_data = sum;
    if (state_q == StClear) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_q;
      wr_data = '0;
    end else if (pend_q && (op_q == pst_pkg::OpAdd)) begin
      wr_en = 1'b1;
    end
  end

  assign rd_en = (state_q == StWalk) && !walk_done;

  // Node memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[cur_q[pst_pkg::PosW-1:0]];
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    cur_d       = cur_q;
    op_d        = op_q;
    delta_d     = delta_q;
    total_d     = total_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    res_valid_d = 1'b0;
    res_total_d = res_total_q;

    // A node read last cycle is folded into the running total.
    if (pend_q && (op_q == pst_pkg::OpQuery)) begin
      total_d = sum;
    end

    case (state_q)
      StClear: begin
        clr_idx_d = clr_idx_q + pst_pkg::PosW'(1);
        if (clr_idx_q == {pst_pkg::PosW{1'b1}}) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          state_d = StWalk;
          cur_d   = {1'b0, position_i};
          op_d    = op_i;
          delta_d = delta_i;
          total_d = '0;
        end
      end
      StWalk: begin
        if (walk_done) begin
          state_d = StDone;
        end else begin
          pend_d      = 1'b1;
          pend_addr_d = cur_q[pst_pkg::PosW-1:0];
          if (op_q == pst_pkg::OpQuery) begin
            cur_d = cur_q & (cur_q - CurW'(1));
          end else begin
            cur_d = cur_q + cur_lsb;
          end
        end
      end
      StDone: begin
        state_d     = StIdle;
        res_valid_d = (op_q == pst_pkg::OpQuery);
        res_total_d = total_q;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_idx_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    op_q        <= op_d;
    delta_q     <= delta_d;
    total_q     <= total_d;
    pend_addr_q <= pend_addr_d;
    res_total_q <= res_total_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign prefix_total_o = res_total_q;

  // A result word only follows the final step of a query.
  a_result_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == StDone) && (op_q == pst_pkg::OpQuery))
    else $error("result word without a finished query");

  // Queries never write the node memory outside the clearing pass.
  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (state_q != StClear)) |-> (op_q == pst_pkg::OpAdd))
    else $error("node write during a query");

  // No node update is left pending once the block is ready again.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pend_q)
    else $error("pending node update while idle");

  // No request is taken during the clearing pass.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |=> (state_q == StClear) || (state_q == StIdle))
    else $error("clearing pass left early");

endmodule

`default_nettype wire

// ===== tb/sv/prefix_sum_tree_table_tb.sv =====
// Self-checking testbench for the prefix-sum tree table: directed words, then random words.
module prefix_sum_tree_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomWords = 1100;
  localparam int unsigned DrainCycles = 16;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic op_i;
  logic [pst_pkg::PosW-1:0] position_i;
  logic [pst_pkg::NodeW-1:0] delta_i;
  logic result_valid_o;
  logic [pst_pkg::NodeW-1:0] prefix_total_o;

  // One row of the directed table; a row with has_total carries its sum typed in.
  typedef struct {
    logic op;
    logic [pst_pkg::PosW-1:0] pos;
    logic [pst_pkg::NodeW-1:0] delta;
    bit has_total;
    logic [pst_pkg::NodeW-1:0] total;
  } word_row_t;

  logic [pst_pkg::NodeW-1:0] node_totals [pst_pkg::TreeSize];
  logic [pst_pkg::NodeW-1:0] pending_totals [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit idling_on = 1'b1;

  always #6 clk_i = ~clk_i;

  prefix_sum_tree_table uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .op_i(op_i),
    .position_i(position_i),
    .delta_i(delta_i),
    .result_valid_o(result_valid_o),
    .prefix_total_o(prefix_total_o)
  );

  // Sum of entries 1..pos, walking down by clearing the lowest set bit.
  function automatic logic [pst_pkg::NodeW-1:0] sum_through(int unsigned pos);
    logic [pst_pkg::NodeW-1:0] total;
    int unsigned idx;
    total = '0;
    idx = (pos > pst_pkg::TreeSize - 1) ? pst_pkg::TreeSize - 1 : pos;
    while (idx != 0) begin
      total += node_totals[idx];
      idx -= idx & (~idx + 1);
    end
    return total;
  endfunction

  // Add delta at pos, walking up by the lowest set bit; position zero is ignored.
  task automatic bump_nodes(int unsigned pos, logic [pst_pkg::NodeW-1:0] delta);
    int unsigned idx;
    idx = pos;
    if (idx != 0) begin
      while (idx < pst_pkg::TreeSize) begin
        node_totals[idx] += delta;
        idx += idx & (~idx + 1);
      end
    end
  endtask

  // Offer one word, possibly after an idle gap, and wait until it is taken.
  task automatic issue_word(logic op, logic [pst_pkg::PosW-1:0] pos,
                            logic [pst_pkg::NodeW-1:0] delta,
                            bit has_total, logic [pst_pkg::NodeW-1:0] total);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    position_i <= pos;
    delta_i <= delta;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // The word is taken at this edge; update the prediction in request order.
    if (op == pst_pkg::OpQuery) begin
      pending_totals.insert(pending_totals.size(),
                            has_total ? total : sum_through(32'(pos)));
    end else begin
      bump_nodes(32'(pos), delta);
    end
  endtask

  // Compare every result word with the oldest expected sum.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h",
                 $time, prefix_total_o);
        mismatch_count++;
      end else if (prefix_total_o !== pending_totals[0]) begin
        $display("%0t: prefix_total mismatch, expected %h, actual %h",
                 $time, pending_totals[0], prefix_total_o);
        mismatch_count++;
        void'(pending_totals.pop_front());
      end else begin
        void'(pending_totals.pop_front());
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    word_row_t rows [$];
    logic op;
    logic [pst_pkg::PosW-1:0] pos;
    logic [pst_pkg::NodeW-1:0] delta;

    rst_ni = 1'b0;
    start = 1'b0;
    op_i = pst_pkg::OpAdd;
    position_i = '0;
    delta_i = '0;
    foreach (node_totals[i]) node_totals[i] = '0;

    // Directed words: empty table, position zero, wrapping, the last node, ignored delta.
    rows = '{
      '{pst_pkg::OpQuery, 10'd0,    64'h0,                  1'b1, 64'h0},
      '{pst_pkg::OpQuery, 10'd1023, 64'h0,                  1'b1, 64'h0},
      '{pst_pkg::OpQuery, 10'd512,  64'h0,                  1'b1, 64'h0},
      '{pst_pkg::OpAdd,   10'd0,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd1023, 64'h0,                  1'b1, 64'h0},
      '{pst_pkg::OpAdd,   10'd1,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd1,    64'h0,                  1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{pst_pkg::OpAdd,   10'd1,    64'h1,                  1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd1,    64'h0,                  1'b1, 64'h0},
      '{pst_pkg::OpQuery, 10'd1023, 64'h0,                  1'b1, 64'h0},
      '{pst_pkg::OpAdd,   10'd1023, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd1023, 64'h0,                  1'b1, 64'h8000_0000_0000_0000},
      '{pst_pkg::OpQuery, 10'd1022, 64'h0,                  1'b1, 64'h0},
      '{pst_pkg::OpAdd,   10'd512,  64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd511,  64'h0,                  1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd512,  64'h0,                  1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd700,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{pst_pkg::OpAdd,   10'd2,    64'h5,                  1'b0, 64'h0},
      '{pst_pkg::OpAdd,   10'd3,    64'h7,                  1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd2,    64'h0,                  1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd3,    64'h0,                  1'b0, 64'h0},
      '{pst_pkg::OpAdd,   10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd1023, 64'h0,                  1'b0, 64'h0},
      '{pst_pkg::OpQuery, 10'd1022, 64'h0,                  1'b0, 64'h0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The clearing pass keeps busy high; issue_word simply waits it out.
    foreach (rows[i]) begin
      issue_word(rows[i].op, rows[i].pos, rows[i].delta, rows[i].has_total, rows[i].total);
    end

    // Random words; a middle stretch runs back to back with no idle gaps.
    for (int unsigned n = 0; n < RandomWords; n++) begin
      idling_on = !(n >= 400 && n < 700);
      op = ($urandom_range(0, 99) < 55) ? pst_pkg::OpAdd : pst_pkg::OpQuery;
      case ($urandom_range(0, 9))
        0: pos = '0;
        1: pos = '1;
        2: pos = 10'd1 << $urandom_range(0, pst_pkg::PosW - 1);
        3, 4: pos = pst_pkg::PosW'($urandom_range(1, 16));
        default: pos = pst_pkg::PosW'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: delta = '1;
        1: delta = '0;
        2: delta = 64'd1 << $urandom_range(0, pst_pkg::NodeW - 1);
        3: delta = pst_pkg::NodeW'($urandom_range(1, 255));
        default: delta = {$urandom, $urandom};
      endcase
      issue_word(op, pos, delta, 1'b0, '0);
    end
    start <= 1'b0;

    // Let the last sums come out, then give the block time to settle.
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pst_pkg.sv
design/prefix_sum_tree_table.sv
tb/sv/prefix_sum_tree_table_tb.sv
